>>> rtl/core/deq_pkg.sv
// Shared types for the double-ended queue: action and status codes,
// and the command bundle from the controller to the datapath.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5,
        ACT_SIZE       = 3'd6,
        ACT_CLEAR      = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DATA  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } deq_cmd_t;

endpackage

>>> rtl/core/deq_ctrl.sv
// Sequencer of the double-ended queue: accept a word, run it, emit the result.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cmd.load = (state_reg == ST_IDLE) && s_valid;
    assign cmd.exec = (state_reg == ST_EXEC);
    assign cmd.emit = (state_reg == ST_DONE) && out_free;

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTH
    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC && !s_ready)
        else $error("accepted word did not start execution");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");
`endif

endmodule

>>> rtl/core/deq_datapath.sv
// Ring-buffer datapath: slot memory, head pointer, occupancy and result register.
// Depends on deq_pkg; driven by deq_ctrl commands.
`timescale 1ns / 1ps

module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  deq_cmd_t                           cmd,
    input  logic [2:0]                         s_action,
    input  logic signed [31:0]                 s_value,
    output logic [1:0]                         m_status,
    output logic signed [31:0]                 m_data,
    output logic [$clog2(DEPTH + 1) - 1:0]     m_count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 2;

    logic [31:0]        mem [DEPTH];
    logic [31:0]        rd_data_reg;

    action_t            act_reg;
    logic [31:0]        value_reg;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    status_t            pend_status_reg, pend_status_next;
    logic               pend_sel_reg, pend_sel_next;
    status_t            out_status_reg;
    logic [31:0]        out_data_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic               is_full, is_empty;
    logic [ADDR_W-1:0]  head_inc, head_dec, tail_pos, back_pos;
    logic [SUM_W-1:0]   tail_sum, back_sum;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;

    assign is_full  = (occ_reg == CNT_W'(DEPTH));
    assign is_empty = (occ_reg == '0);
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign back_sum = tail_sum - SUM_W'(1);
    assign tail_pos = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : ADDR_W'(tail_sum);
    assign back_pos = (back_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back_sum - SUM_W'(DEPTH))
                                                 : ADDR_W'(back_sum);

    always_comb begin
        head_next        = head_reg;
        occ_next         = occ_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        wr_addr          = head_reg;
        rd_addr          = head_reg;
        pend_status_next = STAT_OK;
        pend_sel_next    = 1'b0;
        unique case (act_reg)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (is_full) begin
                    pend_status_next = STAT_FULL;
                end else begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + CNT_W'(1);
                    if (act_reg == ACT_PUSH_FRONT) begin
                        wr_addr   = head_dec;
                        head_next = head_dec;
                    end else begin
                        wr_addr = tail_pos;
                    end
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                if (is_empty) begin
                    pend_status_next = STAT_EMPTY;
                end else begin
                    rd_en            = 1'b1;
                    pend_sel_next    = 1'b1;
                    pend_status_next = STAT_DATA;
                    if (act_reg == ACT_POP_FRONT || act_reg == ACT_PEEK_FRONT) begin
                        rd_addr = head_reg;
                    end else begin
                        rd_addr = back_pos;
                    end
                    if (act_reg == ACT_POP_FRONT) begin
                        head_next = head_inc;
                        occ_next  = occ_reg - CNT_W'(1);
                    end else if (act_reg == ACT_POP_BACK) begin
                        occ_next = occ_reg - CNT_W'(1);
                    end
                end
            end
            ACT_SIZE: begin
                pend_status_next = STAT_OK;
            end
            ACT_CLEAR: begin
                head_next = '0;
                occ_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.exec && rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            occ_reg  <= '0;
        end else if (cmd.exec) begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= action_t'(s_action);
            value_reg <= s_value;
        end
        if (cmd.exec) begin
            pend_status_reg <= pend_status_next;
            pend_sel_reg    <= pend_sel_next;
        end
        if (cmd.emit) begin
            out_status_reg <= pend_status_reg;
            out_data_reg   <= pend_sel_reg ? rd_data_reg : 32'd0;
            out_count_reg  <= occ_reg;
        end
    end

    assign m_status = out_status_reg;
    assign m_data   = out_data_reg;
    assign m_count  = out_count_reg;

`ifndef SYNTH
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> $stable(occ_reg) && $stable(head_reg))
        else $error("pointer state moved without an executing word");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> occ_reg <= CNT_W'(DEPTH) && head_reg <= ADDR_W'(DEPTH - 1))
        else $error("occupancy or head out of range");
`endif

endmodule

>>> rtl/core/double_ended_queue_unit.sv
// Top level of the double-ended queue: ring buffer with head pointer and count.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_action[2:0], s_value[31:0]
//   m_       out        m_valid / m_ready  m_status[1:0], m_data[31:0], m_count
//
// Each word is accepted, executed (one slot memory access and the pointer/count
// update), then the result register is loaded from the registered memory read;
// no word is taken before the last one's result is loaded. s_ready is high only
// in the accept state; the next word is taken while a result still waits on m_.
// A stalled m_ready holds the following word in its done state. aresetn
// (synchronous) empties the queue; slot contents stay undefined until written.
`timescale 1ns / 1ps

module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_action,
    input  logic signed [31:0]             s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic signed [31:0]             m_data,
    output logic [$clog2(DEPTH + 1) - 1:0] m_count
);

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_action (s_action),
        .s_value  (s_value),
        .m_status (m_status),
        .m_data   (m_data),
        .m_count  (m_count)
    );

endmodule
